>>> rtl/srg_pkg.sv
// Shared types, constants and gain table function for the squelch ramp gate.
package srg_pkg;

    localparam int RAMP_W       = 11;
    localparam int PHASE_STEP_W = 17;
    localparam int PHASE_W      = 16;
    localparam int GAIN_W       = 16;
    localparam int GAIN_FRAC    = 15;
    localparam int DIV_STEPS    = 17;
    localparam int DIV_CNT_W    = 5;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [GAIN_W-1:0]  GAIN_ONE   = 16'h8000;
    localparam logic [GAIN_W-1:0]  ROUND_HALF = 16'h4000;
    localparam logic [PHASE_W-1:0] PHASE_MAX  = 16'hFFFF;

    localparam logic REG_RAMP_LENGTH = 1'b0;
    localparam logic REG_GATE_ENABLE = 1'b1;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          Q30_ONE     = 64'sd1073741824;
    localparam longint unsigned GAIN_BIAS   = 64'd17592186044416;
    localparam longint unsigned TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    typedef enum logic [1:0] {
        MODE_MUTED,
        MODE_ATTACK,
        MODE_UNMUTED,
        MODE_DECAY
    } mode_t;

    typedef enum logic [1:0] {
        ENV_HOLD,
        ENV_ONE,
        ENV_ROM
    } env_sel_t;

    typedef struct packed {
        logic     emit;
        logic     zero;
        logic     sob;
        logic     eob;
        logic     unmuted;
        env_sel_t env_sel;
    } item_ctrl_t;

    typedef struct packed {
        mode_t mode;
        logic  start_pending;
        logic  end_pending;
    } ctrl_status_t;

    // Raised-cosine gain sin^2 in Q1.15, built from a Q30 Taylor series
    function automatic logic [GAIN_W-1:0] gain_entry(int unsigned idx, int unsigned tbits);
        longint unsigned x;
        longint unsigned t;
        longint unsigned u;
        longint          s;
        x = (64'(idx) * HALF_PI_Q30) >> tbits;
        t = x;
        s = longint'(x);
        for (int n = 0; n < 8; n++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / TAYLOR_DIV[n];
            if (n[0] == 1'b0)
            begin
                s = s - longint'(t);
            end
            else
            begin
                s = s + longint'(t);
            end
        end
        if (s < 0)
        begin
            s = 0;
        end
        if (s > Q30_ONE)
        begin
            s = Q30_ONE;
        end
        u = 64'(s);
        u = (u * u + GAIN_BIAS) >> 45;
        return GAIN_W'(u);
    endfunction

endpackage

>>> rtl/squelch_ramp_gate.sv
// Squelch gate with raised-cosine attack and decay ramps: top level.
// An accepted item passes the ctrl, gain ROM and scale registers in turn before its result appears.
// Throughput: one item per cycle through the three-stage pipeline while req_stall is low.
// A nonzero ramp_length write holds req_stall high while the divider finds the phase step.
// Reset: mode muted, ramp 0, gate off, envelope one, start flag set, pipeline empty.
module squelch_ramp_gate
    import srg_pkg::*;
#(
    parameter int RAMP_MAX       = 1024,
    parameter int SAMPLE_BITS    = 16,
    parameter int COS_TABLE_BITS = 10
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          mute_request,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          burst_start,
    output logic                          burst_end,
    output logic                          is_unmuted,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready
);

    logic [RAMP_W-1:0]             ramp_length_reg;
    logic                          gate_enable_reg;

    logic                          cfg_wr;
    logic [RAMP_W-1:0]             ramp_wr;
    logic [RAMP_W-1:0]             ramp_clamped;
    logic                          div_start;
    logic                          env_load_one;
    logic                          div_busy;
    logic [PHASE_STEP_W-1:0]       phase_step;

    logic                          advance;
    logic                          accept;

    logic                          a_valid;
    logic signed [SAMPLE_BITS-1:0] a_sample;
    logic [RAMP_W-1:0]             a_step;
    item_ctrl_t                    a_ctrl;
    ctrl_status_t                  status;

    logic                          b_valid;
    logic signed [SAMPLE_BITS-1:0] b_sample;
    item_ctrl_t                    b_ctrl;
    logic [GAIN_W-1:0]             rom_gain;

    assign pready       = 1'b1;
    assign cfg_wr       = psel & penable & pwrite;
    assign ramp_wr      = pwdata[RAMP_W-1:0];
    assign ramp_clamped = (32'(ramp_wr) > 32'(RAMP_MAX)) ? RAMP_W'(RAMP_MAX) : ramp_wr;
    assign div_start    = cfg_wr && (paddr[2] == REG_RAMP_LENGTH);
    assign env_load_one = div_start && (ramp_clamped == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_length_reg <= '0;
            gate_enable_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_RAMP_LENGTH)
            begin
                ramp_length_reg <= ramp_clamped;
            end
            else
            begin
                gate_enable_reg <= pwdata[0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_GATE_ENABLE)
        begin
            prdata = {{(APB_DATA_W-1){1'b0}}, gate_enable_reg};
        end
        else
        begin
            prdata = {{(APB_DATA_W-RAMP_W){1'b0}}, ramp_length_reg};
        end
    end

    assign advance   = !rsp_valid || !rsp_stall;
    assign req_stall = !advance || div_busy;
    assign accept    = req_valid && !req_stall;

    srg_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .divisor    (ramp_clamped),
        .busy       (div_busy),
        .phase_step (phase_step)
    );

    srg_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .advance      (advance),
        .sample_in    (sample_in),
        .mute_request (mute_request),
        .ramp_length  (ramp_length_reg),
        .gate_enable  (gate_enable_reg),
        .a_valid      (a_valid),
        .a_sample     (a_sample),
        .a_step       (a_step),
        .a_ctrl       (a_ctrl),
        .status       (status)
    );

    srg_gain_rom #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_gain_rom (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .a_valid    (a_valid),
        .a_sample   (a_sample),
        .a_step     (a_step),
        .a_ctrl     (a_ctrl),
        .phase_step (phase_step),
        .b_valid    (b_valid),
        .b_sample   (b_sample),
        .b_ctrl     (b_ctrl),
        .rom_gain   (rom_gain)
    );

    srg_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .env_load_one (env_load_one),
        .b_valid      (b_valid),
        .b_sample     (b_sample),
        .b_ctrl       (b_ctrl),
        .rom_gain     (rom_gain),
        .out_valid    (rsp_valid),
        .sample_out   (sample_out),
        .burst_start  (burst_start),
        .burst_end    (burst_end),
        .is_unmuted   (is_unmuted)
    );

    a_attack_exit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status.mode == MODE_ATTACK
        |=> status.mode == MODE_ATTACK || status.mode == MODE_UNMUTED)
        else $error("attack left for a mode other than unmuted");

    a_start_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status.mode == MODE_UNMUTED && status.start_pending
        |=> !status.start_pending)
        else $error("burst start flag not cleared after unmuted item");

    a_phase_step_set: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(div_busy) |-> phase_step != '0)
        else $error("divider finished with a zero phase step");

endmodule

>>> rtl/srg_divider.sv
// Restoring divider that derives the ramp phase step from the ramp length.
module srg_divider
    import srg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [RAMP_W-1:0]       divisor,
    output logic                    busy,
    output logic [PHASE_STEP_W-1:0] phase_step
);

    logic                    busy_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;
    logic [PHASE_STEP_W-1:0] q_reg;
    logic [RAMP_W-1:0]       rem_reg;
    logic [RAMP_W-1:0]       div_reg;

    logic                    dividend_bit;
    logic [RAMP_W:0]         rem_shift;
    logic [RAMP_W:0]         rem_sub;
    logic                    ge;

    always_comb
    begin
        dividend_bit = (cnt_reg == DIV_CNT_W'(DIV_STEPS));
        rem_shift    = {rem_reg, dividend_bit};
        ge           = (rem_shift >= {1'b0, div_reg});
        rem_sub      = rem_shift - {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= '0;
        end
        else if (start)
        begin
            q_reg    <= '0;
            busy_reg <= (divisor != '0);
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[PHASE_STEP_W-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[RAMP_W-1:0] : rem_shift[RAMP_W-1:0];
        end
    end

    assign busy       = busy_reg;
    assign phase_step = q_reg;

endmodule

>>> rtl/srg_ctrl.sv
// Mode machine for muted, attack, unmuted and decay, plus the first pipeline register.
module srg_ctrl
    import srg_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          advance,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          mute_request,
    input  logic [RAMP_W-1:0]             ramp_length,
    input  logic                          gate_enable,
    output logic                          a_valid,
    output logic signed [SAMPLE_BITS-1:0] a_sample,
    output logic [RAMP_W-1:0]             a_step,
    output item_ctrl_t                    a_ctrl,
    output ctrl_status_t                  status
);

    mode_t                         mode_reg;
    mode_t                         mode_next;
    logic [RAMP_W-1:0]             step_reg;
    logic [RAMP_W-1:0]             step_next;
    logic                          start_reg;
    logic                          start_next;
    logic                          end_reg;
    logic                          end_next;
    logic                          end_after;

    logic                          a_valid_reg;
    logic signed [SAMPLE_BITS-1:0] a_sample_reg;
    logic [RAMP_W-1:0]             a_step_reg;
    item_ctrl_t                    a_ctrl_reg;
    item_ctrl_t                    ctrl_next;

    logic                          ramp_on;
    logic [RAMP_W-1:0]             step_inc;
    logic [RAMP_W-1:0]             step_dec;

    always_comb
    begin
        mode_next  = mode_reg;
        step_next  = step_reg;
        start_next = start_reg;
        end_next   = end_reg;
        ramp_on    = (ramp_length != '0);
        step_inc   = step_reg + 1'b1;
        step_dec   = step_reg - 1'b1;
        ctrl_next  = '{emit: 1'b0, zero: 1'b0, sob: 1'b0, eob: 1'b0,
                       unmuted: 1'b0, env_sel: ENV_HOLD};
        unique case (mode_reg)
            MODE_MUTED:
            begin
                if (!mute_request)
                begin
                    if (ramp_on)
                    begin
                        mode_next = MODE_ATTACK;
                    end
                    else
                    begin
                        mode_next  = MODE_UNMUTED;
                        start_next = 1'b1;
                    end
                end
            end
            MODE_UNMUTED:
            begin
                if (start_reg)
                begin
                    start_next    = 1'b0;
                    ctrl_next.sob = 1'b1;
                end
                if (mute_request)
                begin
                    if (ramp_on)
                    begin
                        mode_next = MODE_DECAY;
                    end
                    else
                    begin
                        mode_next = MODE_MUTED;
                        end_next  = 1'b1;
                    end
                end
            end
            MODE_ATTACK:
            begin
                if (ramp_on)
                begin
                    step_next = step_inc;
                end
                if (step_next >= ramp_length)
                begin
                    mode_next         = MODE_UNMUTED;
                    start_next        = 1'b1;
                    ctrl_next.env_sel = ENV_ONE;
                end
                else
                begin
                    ctrl_next.env_sel = ENV_ROM;
                end
            end
            MODE_DECAY:
            begin
                if (!ramp_on || step_reg == '0)
                begin
                    mode_next = MODE_MUTED;
                    end_next  = 1'b1;
                end
                else
                begin
                    step_next         = step_dec;
                    ctrl_next.env_sel = ENV_ROM;
                    if (step_dec == '0)
                    begin
                        mode_next = MODE_MUTED;
                        end_next  = 1'b1;
                    end
                end
            end
        endcase
        ctrl_next.emit    = !(mode_next == MODE_MUTED && gate_enable);
        ctrl_next.zero    = (mode_next == MODE_MUTED);
        ctrl_next.eob     = ctrl_next.emit & end_next;
        ctrl_next.unmuted = (mode_next == MODE_ATTACK) || (mode_next == MODE_UNMUTED);
        end_after         = ctrl_next.emit ? 1'b0 : end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_MUTED;
            step_reg    <= '0;
            start_reg   <= 1'b1;
            end_reg     <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg  <= mode_next;
                step_reg  <= step_next;
                start_reg <= start_next;
                end_reg   <= end_after;
            end
            if (advance)
            begin
                a_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_sample_reg <= sample_in;
            a_step_reg   <= step_next;
            a_ctrl_reg   <= ctrl_next;
        end
    end

    assign a_valid  = a_valid_reg;
    assign a_sample = a_sample_reg;
    assign a_step   = a_step_reg;
    assign a_ctrl   = a_ctrl_reg;
    assign status   = '{mode: mode_reg, start_pending: start_reg, end_pending: end_reg};

endmodule

>>> rtl/srg_gain_rom.sv
// Phase computation and registered gain ROM lookup, the second pipeline stage.
module srg_gain_rom
    import srg_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int COS_TABLE_BITS = 10
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          a_valid,
    input  logic signed [SAMPLE_BITS-1:0] a_sample,
    input  logic [RAMP_W-1:0]             a_step,
    input  item_ctrl_t                    a_ctrl,
    input  logic [PHASE_STEP_W-1:0]       phase_step,
    output logic                          b_valid,
    output logic signed [SAMPLE_BITS-1:0] b_sample,
    output item_ctrl_t                    b_ctrl,
    output logic [GAIN_W-1:0]             rom_gain
);

    localparam int ROM_SIZE = 1 << COS_TABLE_BITS;
    localparam int PROD_W   = RAMP_W + PHASE_STEP_W;

    typedef logic [GAIN_W-1:0] rom_t [ROM_SIZE];

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < ROM_SIZE; i++)
        begin
            r[i] = gain_entry(i, COS_TABLE_BITS);
        end
        return r;
    endfunction

    localparam rom_t GAIN_ROM = build_rom();

    logic [PROD_W-1:0]             product;
    logic [PHASE_W-1:0]            phase;
    logic [COS_TABLE_BITS-1:0]     rom_index;

    logic                          b_valid_reg;
    logic signed [SAMPLE_BITS-1:0] b_sample_reg;
    item_ctrl_t                    b_ctrl_reg;
    logic [GAIN_W-1:0]             gain_reg;

    always_comb
    begin
        product   = {{PHASE_STEP_W{1'b0}}, a_step} * {{RAMP_W{1'b0}}, phase_step};
        phase     = (product > PROD_W'(PHASE_MAX)) ? PHASE_MAX : product[PHASE_W-1:0];
        rom_index = phase[PHASE_W-1 -: COS_TABLE_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_sample_reg <= a_sample;
            b_ctrl_reg   <= a_ctrl;
            gain_reg     <= GAIN_ROM[rom_index];
        end
    end

    assign b_valid  = b_valid_reg;
    assign b_sample = b_sample_reg;
    assign b_ctrl   = b_ctrl_reg;
    assign rom_gain = gain_reg;

endmodule

>>> rtl/srg_scale.sv
// Envelope register, sample scaling with rounding, and the result register.
module srg_scale
    import srg_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          env_load_one,
    input  logic                          b_valid,
    input  logic signed [SAMPLE_BITS-1:0] b_sample,
    input  item_ctrl_t                    b_ctrl,
    input  logic [GAIN_W-1:0]             rom_gain,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          burst_start,
    output logic                          burst_end,
    output logic                          is_unmuted
);

    localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;

    logic [GAIN_W-1:0]             env_reg;
    logic [GAIN_W-1:0]             gain;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      rounded;
    logic signed [SAMPLE_BITS-1:0] scaled;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic                          burst_start_reg;
    logic                          burst_end_reg;
    logic                          is_unmuted_reg;

    always_comb
    begin
        unique case (b_ctrl.env_sel)
            ENV_HOLD: gain = env_reg;
            ENV_ONE:  gain = GAIN_ONE;
            ENV_ROM:  gain = rom_gain;
            default:  gain = env_reg;
        endcase
        prod    = b_sample * $signed({1'b0, gain});
        rounded = prod + $signed(PROD_W'(ROUND_HALF));
        scaled  = rounded[GAIN_FRAC +: SAMPLE_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg       <= GAIN_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (env_load_one)
            begin
                env_reg <= GAIN_ONE;
            end
            else if (advance && b_valid)
            begin
                env_reg <= gain;
            end
            if (advance)
            begin
                out_valid_reg <= b_valid & b_ctrl.emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sample_out_reg  <= b_ctrl.zero ? '0 : scaled;
            burst_start_reg <= b_ctrl.sob;
            burst_end_reg   <= b_ctrl.eob;
            is_unmuted_reg  <= b_ctrl.unmuted;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign burst_start = burst_start_reg;
    assign burst_end   = burst_end_reg;
    assign is_unmuted  = is_unmuted_reg;

endmodule
